### src/pfa_pkg.sv
// Shared types, codes and defaults for the page frame allocator.
// Used by pfa_front, pfa_queue, pfa_back and page_frame_allocator_refcount.
package pfa_pkg;

  localparam int unsigned NumFramesDef = 32768;
  localparam int unsigned CountBitsDef = 8;

  localparam int unsigned FrameW  = 16;
  localparam int unsigned ValueW  = 15;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [CfgW-1:0] FirstFreeRst  = 16'd0;
  localparam logic [CfgW-1:0] FrameLimitRst = 16'd32768;

  localparam logic CFG_FIRST_FREE  = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  localparam logic [2:0] OPC_ALLOC = 3'd0;
  localparam logic [2:0] OPC_FREE  = 3'd1;
  localparam logic [2:0] OPC_GET   = 3'd2;
  localparam logic [2:0] OPC_INC   = 3'd3;
  localparam logic [2:0] OPC_DEC   = 3'd4;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOMEM      = 3'd1,
    ST_BADFRAME   = 3'd2,
    ST_REFERENCED = 3'd3,
    ST_LIMIT      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE,
    K_GET,
    K_INC,
    K_DEC,
    K_NOP
  } kind_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_EXEC
  } back_state_e;

  typedef struct packed {
    kind_e              kind;
    logic               bad;
    logic [FrameW-1:0]  frame;
  } cmd_t;

endpackage

### src/pfa_front.sv
// Front end: configuration registers, opcode decode and frame range checks.
// Depends on pfa_pkg; feeds classified commands to pfa_queue.
module pfa_front
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic [2:0]        opcode_i,
  input  logic [FrameW-1:0] frame_i,
  output cmd_t              cmd_o
);

  logic [CfgW-1:0] first_free_q, first_free_d;
  logic [CfgW-1:0] limit_q, limit_d;
  logic            in_store;
  logic            in_range;

  always_comb begin
    first_free_d = first_free_q;
    limit_d      = limit_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FIRST_FREE:  first_free_d = cfg_wdata_i;
        CFG_FRAME_LIMIT: limit_d      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_free_q <= FirstFreeRst;
      limit_q      <= FrameLimitRst;
    end else begin
      first_free_q <= first_free_d;
      limit_q      <= limit_d;
    end
  end

  assign in_store = {1'b0, frame_i} < 17'(NUM_FRAMES);
  assign in_range = in_store && (frame_i >= first_free_q) && (frame_i < limit_q);

  always_comb begin
    cmd_o.frame = frame_i;
    cmd_o.bad   = 1'b0;
    case (opcode_i)
      OPC_ALLOC: cmd_o.kind = K_ALLOC;
      OPC_FREE: begin
        cmd_o.kind = K_FREE;
        cmd_o.bad  = !in_range;
      end
      OPC_GET: begin
        cmd_o.kind = K_GET;
        cmd_o.bad  = !in_store;
      end
      OPC_INC: begin
        cmd_o.kind = K_INC;
        cmd_o.bad  = !in_store;
      end
      OPC_DEC: begin
        cmd_o.kind = K_DEC;
        cmd_o.bad  = !in_store;
      end
      default: cmd_o.kind = K_NOP;
    endcase
  end

endmodule

### src/pfa_queue.sv
// Two-entry command queue between front and back end.
// Depends on pfa_pkg for the command type.
module pfa_queue
  import pfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### src/pfa_back.sv
// Back end: free list head, link and count memories, execution and result register.
// Depends on pfa_pkg; takes commands from pfa_queue.
module pfa_back
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  cmd_t                q_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ValueW-1:0]   value_o,
  output status_e             status_o
);

  localparam int unsigned IdxW = $clog2(NUM_FRAMES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] cnt_mem  [NUM_FRAMES];
  logic [IdxW:0]         link_mem [NUM_FRAMES];

  back_state_e state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  cmd_t            cmd_q;
  logic [IdxW-1:0] head_q, head_d;
  logic            empty_q, empty_d;
  logic            out_valid_q, out_valid_d;
  logic [ValueW-1:0] value_q, value_d;
  status_e         status_q, status_d;

  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [IdxW:0]         link_rd_q;
  logic                  rd_en;
  logic                  cnt_we, link_we;
  logic [IdxW-1:0]       cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [IdxW-1:0]       idx;
  logic [31:0]           cnt_ext, head_ext;
  logic                  load;

  assign idx      = cmd_q.frame[IdxW-1:0];
  assign cnt_ext  = 32'(cnt_rd_q);
  assign head_ext = 32'(head_q);
  assign load     = (state_q == BS_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    empty_d     = empty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    status_d    = status_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    cnt_we      = 1'b0;
    cnt_wa      = idx;
    cnt_wd      = cnt_rd_q;
    link_we     = 1'b0;
    case (state_q)
      BS_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_q;
        cnt_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          rd_en   = 1'b1;
          state_d = BS_EXEC;
        end
      end
      BS_EXEC: begin
        if (load) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          status_d    = ST_OK;
          state_d     = BS_IDLE;
          case (cmd_q.kind)
            K_ALLOC: begin
              if (empty_q) begin
                status_d = ST_NOMEM;
              end else begin
                value_d = head_ext[ValueW-1:0];
                head_d  = link_rd_q[IdxW-1:0];
                empty_d = link_rd_q[IdxW];
              end
            end
            K_FREE: begin
              if (cmd_q.bad) begin
                status_d = ST_BADFRAME;
              end else if (cnt_rd_q != '0) begin
                status_d = ST_REFERENCED;
              end else begin
                link_we = 1'b1;
                head_d  = idx;
                empty_d = 1'b0;
              end
            end
            K_GET: begin
              if (cmd_q.bad) begin
                status_d = ST_BADFRAME;
              end else begin
                value_d = cnt_ext[ValueW-1:0];
              end
            end
            K_INC: begin
              if (cmd_q.bad) begin
                status_d = ST_BADFRAME;
              end else if (cnt_rd_q == CountMax) begin
                status_d = ST_LIMIT;
              end else begin
                cnt_we = 1'b1;
                cnt_wd = cnt_rd_q + 1'b1;
              end
            end
            K_DEC: begin
              if (cmd_q.bad) begin
                status_d = ST_BADFRAME;
              end else if (cnt_rd_q == '0) begin
                status_d = ST_LIMIT;
              end else begin
                cnt_we = 1'b1;
                cnt_wd = cnt_rd_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cnt_rd_q  <= cnt_mem[q_cmd_i.frame[IdxW-1:0]];
      link_rd_q <= link_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[idx] <= {empty_q, head_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_CLEAR) |-> !pop_o)
    else $error("command taken during clearing pass");

  a_pop_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BS_EXEC))
    else $error("popped command not executed");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> (value_q == '0))
    else $error("error result carries a nonzero value");

  a_empty_nomem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (cmd_q.kind == K_ALLOC) && empty_q) |=> (status_q == ST_NOMEM))
    else $error("alloc on empty list did not report out of memory");

endmodule

### src/page_frame_allocator_refcount.sv
// Page frame allocator with per-frame reference counts, built from
// pfa_front, pfa_queue and pfa_back; depends on pfa_pkg.
//
// Each operation (alloc, free, get, increment, decrement) runs in the back end
// in BS_IDLE, which reads the count memory and the link memory at the head, and
// then in BS_EXEC, which waits until the result register is empty or taken and
// then updates them and the head and loads the result register. The front end
// classifies and the queue holds up to two operations meanwhile, so results
// that wait on m_axis_tready do not block new transfers until the queue fills.
// After reset the back end clears the count memory, one entry a cycle, from 0 to
// NUM_FRAMES-1 before its first operation; configuration writes are taken meanwhile.
module page_frame_allocator_refcount
  import pfa_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // opcode[2:0], frame[18:3], zero fill
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // result_value[14:0], status[17:15], zero fill
);

  cmd_t              front_cmd;
  cmd_t              q_head;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;
  logic [ValueW-1:0] value;
  status_e           status;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  pfa_front #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (s_axis_tdata[2:0]),
    .frame_i     (s_axis_tdata[18:3]),
    .cmd_o       (front_cmd)
  );

  pfa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  pfa_back #(
    .NUM_FRAMES (NUM_FRAMES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (value),
    .status_o    (status)
  );

  assign m_axis_tdata = {6'd0, status, value};

endmodule
